// ----- hdl/splitmix64_ranged_random_core_macros.svh -----
// Assertion macros for the splitmix64 ranged random core.
// Relies on signals named clk and rst in the module that uses them.
`ifndef SPLITMIX64_RANGED_RANDOM_CORE_MACROS_SVH
`define SPLITMIX64_RANGED_RANDOM_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked while out of reset.
`define SMR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smr: same-cycle check failed");
// Next-cycle implication, checked while out of reset.
`define SMR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smr: next-cycle check failed");
`else
`define SMR_ASSERT_IMP(lbl, ante, cons)
`define SMR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/smr_pkg.sv -----
// Shared types and constants for the splitmix64 ranged random core.
// No dependencies; used by smr_arith and the top level.
package smr_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned FRAC_W        = 53;
  localparam int unsigned SMR_MUL_DIGIT = 8;

  localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

  // Command codes. Code 3 behaves as a fraction draw.
  typedef enum logic [1:0] {
    CMD_FRACTION   = 2'd0,
    CMD_UNIT_RANGE = 2'd1,
    CMD_RANGE      = 2'd2
  } cmd_t;

  typedef enum logic [0:0] {
    ARITH_MUL = 1'b0,
    ARITH_MOD = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_A,
    ST_WAIT_A,
    ST_MIX_B,
    ST_WAIT_B,
    ST_SPAN,
    ST_DECIDE,
    ST_WAIT_MOD,
    ST_DONE
  } state_t;

endpackage

// ----- hdl/smr_arith.sv -----
// Shared iterative arithmetic unit: 64-bit low-half multiply, digit serial,
// and 64-bit unsigned modulo by restoring division. Depends on smr_pkg.
module smr_arith import smr_pkg::*; #(
  parameter int unsigned MulDigit = SMR_MUL_DIGIT
) (
  input  logic              clk,
  input  logic              rst,
  input  arith_req_t        req,
  input  logic [WORD_W-1:0] opa,
  input  logic [WORD_W-1:0] opb,
  output arith_stat_t       stat,
  output logic [WORD_W-1:0] result
);

  localparam int unsigned MulSteps = WORD_W / MulDigit;
  localparam int unsigned CntW     = $clog2(WORD_W);

  logic [WORD_W-1:0]          acc;
  logic [WORD_W-1:0]          opa_r;
  logic [WORD_W-1:0]          opb_r;
  arith_op_t                  op_r;
  logic                       busy;
  logic                       done;
  logic [CntW-1:0]            cnt;

  logic [WORD_W-1:0]          prod;
  logic [WORD_W-1:0]          mul_sum;
  logic [WORD_W:0]            trial;
  logic [WORD_W+1:0]          diff;
  logic [WORD_W-1:0]          rem_next;

  // Multiply: one digit of the multiplier per cycle, multiplicand shifts up.
  always_comb begin
    prod    = opa_r * WORD_W'(opb_r[MulDigit-1:0]);
    mul_sum = acc + prod;
  end

  // Modulo: shift in one dividend bit, subtract the divisor when it fits.
  always_comb begin
    trial    = {acc, opa_r[WORD_W-1]};
    diff     = {1'b0, trial} - {2'b00, opb_r};
    rem_next = diff[WORD_W+1] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op_r  <= req.op;
        acc   <= '0;
        opa_r <= opa;
        opb_r <= opb;
        cnt   <= (req.op == ARITH_MUL) ? CntW'(MulSteps - 1) : CntW'(WORD_W - 1);
      end else if (busy) begin
        unique case (op_r)
          ARITH_MUL: begin
            acc   <= mul_sum;
            opa_r <= opa_r << MulDigit;
            opb_r <= opb_r >> MulDigit;
          end
          ARITH_MOD: begin
            acc   <= rem_next;
            opa_r <= opa_r << 1;
          end
          default: begin
            acc <= acc;
          end
        endcase
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = acc;

endmodule

// ----- hdl/splitmix64_ranged_random_core.sv -----
// Top level of the splitmix64 ranged random core: sequencer, seed state and
// result register. Depends on smr_pkg, smr_arith and the assertion macros.
`include "splitmix64_ranged_random_core_macros.svh"

// How to use this block:
// The request channel (req_valid, req_stall) carries command, lower_bound and
// upper_bound; a transaction happens at a rising edge with req_valid high and
// req_stall low. Each transaction yields exactly one response transaction on
// rsp_valid / rsp_stall carrying ranged_value, fraction_bits, empty_interval.
// The seed is written through cfg_valid / cfg_ready with initial_seed as data;
// the write also reloads the running seed. Writes are taken only while idle.
// Every request first advances the running seed, then mixes it with two
// multiplies on the shared arithmetic unit (MulDigit bits per cycle). A
// fraction draw then goes to the done state; an empty interval or a full
// 64-bit span passes the decide state first, and a range draw adds a
// restoring modulo on the same unit. The sequencer returns to idle in the
// same cycle as the response turns valid, and the next request can be taken
// from then on. The sequencer stalls the request channel until the result
// sits in the output register, which lets the next request start while a
// response waits; under a long receiver stall the next result waits in the
// done state. Reset (rst, synchronous) clears the running seed to zero and
// empties the output register.
module splitmix64_ranged_random_core import smr_pkg::*; #(
  parameter int unsigned MulDigit = SMR_MUL_DIGIT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [WORD_W-1:0]        initial_seed,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               command,
  input  logic signed [WORD_W-1:0] lower_bound,
  input  logic signed [WORD_W-1:0] upper_bound,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic signed [WORD_W-1:0] ranged_value,
  output logic [FRAC_W-1:0]        fraction_bits,
  output logic                     empty_interval
);

  state_t            state;
  state_t            state_next;

  logic [WORD_W-1:0] running_seed;
  logic              frac_r;
  logic [WORD_W-1:0] lo_r;
  logic [WORD_W-1:0] hi_r;
  logic [WORD_W-1:0] z;
  logic [WORD_W-1:0] span;
  logic              empty_r;
  logic [WORD_W-1:0] res_value;
  logic [FRAC_W-1:0] res_frac;
  logic              res_empty;

  arith_req_t        arith_req;
  arith_stat_t       arith_stat;
  logic [WORD_W-1:0] arith_opa;
  logic [WORD_W-1:0] arith_opb;
  logic [WORD_W-1:0] arith_result;

  logic              req_take;
  logic              cfg_take;
  logic              out_free;

  assign req_take = req_valid && !req_stall;
  assign cfg_take = cfg_valid && cfg_ready;
  assign out_free = !rsp_valid || !rsp_stall;

  smr_arith #(
    .MulDigit(MulDigit)
  ) u_arith (
    .clk   (clk),
    .rst   (rst),
    .req   (arith_req),
    .opa   (arith_opa),
    .opb   (arith_opb),
    .stat  (arith_stat),
    .result(arith_result)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (req_take) state_next = ST_MIX_A;
      ST_MIX_A:    state_next = ST_WAIT_A;
      ST_WAIT_A:   if (arith_stat.done) state_next = ST_MIX_B;
      ST_MIX_B:    state_next = ST_WAIT_B;
      ST_WAIT_B:   if (arith_stat.done) state_next = ST_SPAN;
      ST_SPAN:     state_next = frac_r ? ST_DONE : ST_DECIDE;
      ST_DECIDE: begin
        if (empty_r || span == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_WAIT_MOD;
        end
      end
      ST_WAIT_MOD: if (arith_stat.done) state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes and the shared unit's operands.
  always_comb begin
    cfg_ready       = (state == ST_IDLE);
    // A seed write in the same cycle takes precedence over a request.
    req_stall       = (state != ST_IDLE) || cfg_valid;
    arith_req.start = 1'b0;
    arith_req.op    = ARITH_MUL;
    arith_opa       = z;
    arith_opb       = span;
    unique case (state)
      ST_MIX_A: begin
        arith_req.start = 1'b1;
        arith_opa       = running_seed ^ (running_seed >> 30);
        arith_opb       = MIX_MUL_A;
      end
      ST_MIX_B: begin
        arith_req.start = 1'b1;
        arith_opa       = z ^ (z >> 27);
        arith_opb       = MIX_MUL_B;
      end
      ST_DECIDE: begin
        arith_req.start = !empty_r && (span != '0);
        arith_req.op    = ARITH_MOD;
      end
      default: begin
        arith_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Seed state: a configuration write reloads it, each request advances it.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_seed <= '0;
    end else if (cfg_take) begin
      running_seed <= initial_seed;
    end else if (req_take) begin
      running_seed <= running_seed + GOLDEN_STEP;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    if (req_take) begin
      frac_r <= !(command == CMD_UNIT_RANGE || command == CMD_RANGE);
      lo_r   <= (command == CMD_UNIT_RANGE) ? WORD_W'(1) : lower_bound;
      hi_r   <= upper_bound;
    end
    unique case (state)
      ST_WAIT_A: begin
        if (arith_stat.done) z <= arith_result;
      end
      ST_WAIT_B: begin
        if (arith_stat.done) z <= arith_result ^ (arith_result >> 31);
      end
      ST_SPAN: begin
        span      <= hi_r - lo_r + WORD_W'(1);
        empty_r   <= $signed(lo_r) > $signed(hi_r);
        res_value <= '0;
        res_frac  <= frac_r ? z[WORD_W-1:WORD_W-FRAC_W] : '0;
        res_empty <= 1'b0;
      end
      ST_DECIDE: begin
        // A full 64-bit span wraps to zero; the draw is then lower plus z.
        if (empty_r) begin
          res_empty <= 1'b1;
        end else if (span == '0) begin
          res_value <= lo_r + z;
        end
      end
      ST_WAIT_MOD: begin
        if (arith_stat.done) res_value <= lo_r + arith_result;
      end
      default: begin
        res_empty <= res_empty;
      end
    endcase
  end

  // Output register; it is refilled only once the previous response is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      ranged_value   <= res_value;
      fraction_bits  <= res_frac;
      empty_interval <= res_empty;
    end
  end

  `SMR_ASSERT_NXT(a_seed_step, req_take, state == ST_MIX_A && running_seed == $past(running_seed) + GOLDEN_STEP)
  `SMR_ASSERT_IMP(a_busy_in_wait, arith_stat.busy, state == ST_WAIT_A || state == ST_WAIT_B || state == ST_WAIT_MOD)
  `SMR_ASSERT_IMP(a_empty_zero, rsp_valid && empty_interval, ranged_value == '0 && fraction_bits == '0)
  `SMR_ASSERT_NXT(a_done_loads, state == ST_DONE && !rsp_valid, rsp_valid && state == ST_IDLE)

endmodule

// ----- test/splitmix64_ranged_random_core_tb.sv -----
// Self-checking testbench for splitmix64_ranged_random_core: a scoreboard class
// predicts every draw, and plain tasks drive the request and seed ports while an
// always block drives the response stall. Depends on smr_pkg and the core RTL only.
module splitmix64_ranged_random_core_tb;
  import smr_pkg::*;

  // Command code 3 has no name in the package; the core treats it as a fraction draw.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [WORD_W-1:0] S_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] S_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] ALL_1S = 64'hFFFF_FFFF_FFFF_FFFF;

  // Cycles without any transaction on any port before the run is declared hung.
  // A range draw is the longest, and the random stalls are short.
  localparam int HANG_LIMIT = 5000;
  // Quiet time after the last response, a little above the longest draw.
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_REPORTS = 10;

  // One response as the core presents it.
  typedef struct packed {
    logic signed [WORD_W-1:0] ranged;
    logic [FRAC_W-1:0]        frac;
    logic                     empty;
  } draw_t;

  // The scoreboard keeps its own copy of the running seed, advances it once for
  // every accepted request, and queues the draw that the request must produce.
  class draw_scoreboard;
    logic [WORD_W-1:0] seed;
    draw_t             owed_draws[$];
    int                mismatches;

    function new();
      seed = '0;
      mismatches = 0;
    endfunction

    function void load_seed(logic [WORD_W-1:0] value);
      seed = value;
    endfunction

    function int pending();
      return owed_draws.size();
    endfunction

    // Golden-ratio step followed by the splitmix64 finalizer.
    function logic [WORD_W-1:0] advance_and_mix();
      logic [WORD_W-1:0] z;
      seed = seed + GOLDEN_STEP;
      z = seed;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
    endfunction

    function void note_request(logic [1:0] cmd, logic [WORD_W-1:0] lo_in,
                               logic [WORD_W-1:0] hi_in);
      draw_t             want;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] span;
      z = advance_and_mix();
      want = '0;
      if (cmd == CMD_FRACTION || cmd == CMD_SPARE) begin
        want.frac = z[WORD_W-1:WORD_W-FRAC_W];
      end else begin
        hi = hi_in;
        lo = (cmd == CMD_UNIT_RANGE) ? 64'd1 : lo_in;
        if ($signed(lo) > $signed(hi)) begin
          want.empty = 1'b1;
        end else begin
          span = hi - lo + 64'd1;
          // A span of the whole 64-bit range wraps to zero and returns lower + z.
          if (span == '0) want.ranged = lo + z;
          else want.ranged = lo + (z % span);
        end
      end
      owed_draws = {owed_draws, want};
    endfunction

    function void check_result(logic [WORD_W-1:0] rv, logic [FRAC_W-1:0] fb, logic ei);
      draw_t want;
      if (owed_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: response with no request outstanding: value=%h frac=%h empty=%b",
                   rv, fb, ei);
        return;
      end
      want = owed_draws.pop_front();
      if (want.ranged !== rv || want.frac !== fb || want.empty !== ei) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: draw mismatch: want value=%h frac=%h empty=%b",
                   want.ranged, want.frac, want.empty);
          $display("                       got value=%h frac=%h empty=%b", rv, fb, ei);
        end
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [WORD_W-1:0]        initial_seed = '0;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [1:0]               command = CMD_FRACTION;
  logic signed [WORD_W-1:0] lower_bound = '0;
  logic signed [WORD_W-1:0] upper_bound = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic signed [WORD_W-1:0] ranged_value;
  logic [FRAC_W-1:0]        fraction_bits;
  logic                     empty_interval;

  // While this is low neither side inserts idle cycles.
  logic idling_on = 1'b1;
  int   hang_count = 0;

  draw_scoreboard book = new();

  splitmix64_ranged_random_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .initial_seed   (initial_seed),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .command        (command),
    .lower_bound    (lower_bound),
    .upper_bound    (upper_bound),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .ranged_value   (ranged_value),
    .fraction_bits  (fraction_bits),
    .empty_interval (empty_interval)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls in about six percent of cycles, unless idling is off.
  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= idling_on && ($urandom_range(99) < 6);
  end

  // Monitor. Everything is sampled right at the rising edge, so the values seen
  // are the ones the core saw when it took the transaction. The response is
  // checked before a request from the same edge is noted, since a response
  // always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) book.check_result(ranged_value, fraction_bits, empty_interval);
      if (req_valid && !req_stall) book.note_request(command, lower_bound, upper_bound);
      if (cfg_valid && cfg_ready) book.load_seed(initial_seed);
    end
  end

  // Watchdog: counts cycles in which no port moves a transaction.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      hang_count <= 0;
    end else begin
      hang_count <= hang_count + 1;
      if (hang_count >= HANG_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", HANG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Bounds are a mix of full-width values, small signed values near zero, the
  // extremes, and values of random magnitude with either sign.
  function automatic logic [WORD_W-1:0] pick_bound();
    logic [WORD_W-1:0] v;
    case ($urandom_range(4))
      0: v = rand_word();
      1: v = $signed(64'($urandom_range(40))) - 64'sd20;
      2: begin
        case ($urandom_range(4))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = '0;
          3: v = ALL_1S;
          default: v = 64'd1;
        endcase
      end
      default: begin
        v = rand_word() >> $urandom_range(63);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Presents one request and returns right after the edge that accepts it.
  // Valid stays high into the next request when no idle cycle falls between.
  task automatic send_draw(input logic [1:0] cmd, input logic [WORD_W-1:0] lo,
                           input logic [WORD_W-1:0] hi);
    while (idling_on && $urandom_range(99) < 6) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    command     <= cmd;
    lower_bound <= lo;
    upper_bound <= hi;
    do @(posedge clk); while (req_stall);
  endtask

  // Builds one random request. Most are range draws, mostly with well-ordered bounds,
  // so the modulo path sees every kind of span; the rest are fraction draws,
  // unit-range draws, unordered bounds and deliberately empty intervals.
  task automatic send_random_draw();
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_draw(CMD_FRACTION, rand_word(), rand_word());
    end else if (pick < 18) begin
      send_draw(CMD_SPARE, rand_word(), rand_word());
    end else if (pick < 40) begin
      send_draw(CMD_UNIT_RANGE, rand_word(), pick_bound());
    end else begin
      a = pick_bound();
      b = pick_bound();
      pick = $urandom_range(99);
      if (pick < 55) begin
        if ($signed(a) > $signed(b)) send_draw(CMD_RANGE, b, a);
        else send_draw(CMD_RANGE, a, b);
      end else if (pick < 75) begin
        // Narrow span; near the top of the range the sum may wrap and go empty.
        send_draw(CMD_RANGE, a, a + 64'($urandom_range(300)));
      end else if (pick < 90) begin
        send_draw(CMD_RANGE, rand_word(), rand_word());
      end else begin
        if ($signed(a) > $signed(b)) send_draw(CMD_RANGE, a, b);
        else if (a != b) send_draw(CMD_RANGE, b, a);
        else send_draw(CMD_RANGE, a + 64'd1, a);
      end
    end
  endtask

  // Waits until every owed response has been taken, so the core is idle. The
  // first edge lets the monitor note a request accepted at the edge just past.
  task automatic wait_drained();
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Seed writes happen only with the core idle: request valid low, nothing owed.
  task automatic write_seed(input logic [WORD_W-1:0] value);
    req_valid <= 1'b0;
    wait_drained();
    cfg_valid    <= 1'b1;
    initial_seed <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed draws from the seed left by reset. They cover both fraction
    // codes, the unit range at its edges, an empty interval for both range
    // commands, the full 64-bit span that wraps to zero, spans of one, half
    // the range and all but one value, and the signed extremes on each side.
    send_draw(CMD_FRACTION, ALL_1S, ALL_1S);
    send_draw(CMD_SPARE, '0, '0);
    send_draw(CMD_UNIT_RANGE, S_MIN, 64'd1);
    send_draw(CMD_UNIT_RANGE, S_MAX, '0);
    send_draw(CMD_UNIT_RANGE, '0, ALL_1S);
    send_draw(CMD_UNIT_RANGE, ALL_1S, S_MIN);
    send_draw(CMD_UNIT_RANGE, '0, S_MAX);
    send_draw(CMD_UNIT_RANGE, '0, 64'd6);
    send_draw(CMD_RANGE, S_MIN, S_MAX);
    send_draw(CMD_RANGE, S_MIN, S_MAX);
    send_draw(CMD_RANGE, '0, '0);
    send_draw(CMD_RANGE, S_MIN, S_MIN);
    send_draw(CMD_RANGE, S_MAX, S_MAX);
    send_draw(CMD_RANGE, S_MAX, S_MIN);
    send_draw(CMD_RANGE, 64'd1, '0);
    send_draw(CMD_RANGE, -64'sd10, 64'sd10);
    send_draw(CMD_RANGE, S_MIN, ALL_1S);
    send_draw(CMD_RANGE, '0, S_MAX);
    send_draw(CMD_RANGE, ALL_1S, S_MAX);
    send_draw(CMD_RANGE, S_MIN + 64'd1, S_MAX);
    repeat (200) send_random_draw();

    // Each later phase starts from a new seed; the one with a random seed runs without any idling.
    write_seed(ALL_1S);
    send_draw(CMD_RANGE, S_MIN, S_MAX);
    repeat (225) send_random_draw();

    write_seed(rand_word());
    idling_on <= 1'b0;
    repeat (225) send_random_draw();

    write_seed('0);
    idling_on <= 1'b1;
    send_draw(CMD_FRACTION, '0, '0);
    repeat (225) send_random_draw();

    write_seed(S_MIN);
    repeat (225) send_random_draw();

    // Let the last responses come back, then give the core time to show any
    // stray response before the verdict.
    req_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
